// ----- hdl/rar_pkg.sv -----
`default_nettype none
package rar_pkg;
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  localparam int unsigned WordW = 64;
  localparam int unsigned ShiftW = 7;

  typedef logic [WordW-1:0] word_t;
endpackage
`default_nettype wire

// ----- hdl/rar_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle. Exact division assumed by caller.
module rar_div (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              go_i,
  input  rar_pkg::word_t   dividend_i,
  input  rar_pkg::word_t   divisor_i,
  output logic             done_o,
  output rar_pkg::word_t   quot_o
);
  import rar_pkg::*;

  logic              run_q;
  logic [ShiftW-1:0] cnt_q;
  word_t             rem_q, quo_q, dvs_q;
  logic [WordW:0]    trial;
  logic [WordW:0]    rem_sh;

  assign rem_sh = {rem_q, quo_q[WordW-1]};
  assign trial  = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        rem_q <= '0;
        quo_q <= dividend_i;
        dvs_q <= divisor_i;
      end else if (run_q) begin
        if (!trial[WordW]) begin
          rem_q <= trial[WordW-1:0];
          quo_q <= {quo_q[WordW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[WordW-1:0];
          quo_q <= {quo_q[WordW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ShiftW'(WordW - 1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quot_o = quo_q;
endmodule
`default_nettype wire

// ----- hdl/rational_arith_reduce_core.sv -----
`default_nettype none
// Rational ALU: add/sub/mul/div of two signed fractions, result reduced to
// lowest terms with a positive denominator. Pulse start_i while busy_o is low;
// exactly one result appears later for one cycle with valid_o high. There is
// no back-pressure: the receiver must capture the result in that cycle.
// Steps after the accepting edge: a shared 32x32 multiplier forms two
// products, then the denominator product with the combine; then the sign
// and zero checks, then a binary GCD (each step one shift or one 64-bit
// subtract), then two divisions on a shared restoring divider, then the
// output state. Zero numerator or zero denominator returns the result from
// the check state and skips the GCD and the divisions.
// div_zero_o flags a zero result denominator (division by zero); result 0/1.
module rational_arith_reduce_core #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [1:0]  func_i,
  input  wire  [31:0] a_numer_i,
  input  wire  [30:0] a_denom_i,
  input  wire  [31:0] b_numer_i,
  input  wire  [30:0] b_denom_i,
  output logic        valid_o,
  output logic [63:0] res_numer_o,
  output logic [62:0] res_denom_o,
  output logic        div_zero_o
);
  import rar_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_COMB, S_CHK, S_G2, S_GU, S_GV, S_GSUB,
    S_DIVN, S_DIVD, S_OUT
  } state_e;

  localparam int unsigned DW = OPERAND_WIDTH - 1;

  state_e state_q;
  logic [1:0] func_q;
  logic signed [31:0] an_q, ad_q, bn_q, bd_q;
  logic signed [63:0] p1_q, p2_q, num_q, den_q;
  logic neg_q;
  word_t nm_q, dm_q, u_q, v_q, g_q, qn_q;
  logic [ShiftW-1:0] sh_q;

  // shared multiplier (operands at most 32x32 signed)
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    if (state_q == S_MUL2) begin
      unique case (func_e'(func_q))
        FUNC_MUL: begin mul_a = an_q; mul_b = bn_q; end
        FUNC_DIV: begin mul_a = bn_q; mul_b = ad_q; end
        default:  begin mul_a = bn_q; mul_b = ad_q; end
      endcase
    end else if (state_q == S_COMB) begin
      mul_a = ad_q;
      mul_b = bd_q;
    end
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // shared 64-bit subtractor for GCD
  word_t umin, umax, diff;
  assign umin = (u_q > v_q) ? v_q : u_q;
  assign umax = (u_q > v_q) ? u_q : v_q;
  assign diff = umax - umin;

  logic  dv_go, dv_done;
  word_t dv_a, dv_quot;
  assign dv_a = (state_q == S_DIVD) ? dm_q : nm_q;

  rar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (dv_go),
    .dividend_i (dv_a),
    .divisor_i  (g_q),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  logic dv_go_q;
  assign dv_go = dv_go_q;

  logic signed [OPERAND_WIDTH-1:0] an_w, bn_w;
  logic [DW-1:0] ad_w, bd_w;
  assign an_w = a_numer_i[OPERAND_WIDTH-1:0];
  assign bn_w = b_numer_i[OPERAND_WIDTH-1:0];
  assign ad_w = a_denom_i[DW-1:0];
  assign bd_w = b_denom_i[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_o    <= 1'b0;
      dv_go_q    <= 1'b0;
      div_zero_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      dv_go_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          func_q  <= func_i;
          an_q    <= 32'(an_w);
          bn_q    <= 32'(bn_w);
          ad_q    <= 32'(ad_w);
          bd_q    <= 32'(bd_w);
          state_q <= S_MUL1;
        end
        S_MUL1: begin p1_q <= mul_p; state_q <= S_MUL2; end
        S_MUL2: begin p2_q <= mul_p; state_q <= S_COMB; end
        S_COMB: begin
          unique case (func_e'(func_q))
            FUNC_ADD: begin num_q <= p1_q + p2_q; den_q <= mul_p; end
            FUNC_SUB: begin num_q <= p1_q - p2_q; den_q <= mul_p; end
            FUNC_MUL: begin num_q <= p2_q; den_q <= mul_p; end
            FUNC_DIV: begin num_q <= p1_q; den_q <= p2_q; end
          endcase
          state_q <= S_CHK;
        end
        S_CHK: begin
          neg_q <= num_q[63] ^ den_q[63];
          nm_q  <= num_q[63] ? word_t'(-num_q) : word_t'(num_q);
          dm_q  <= den_q[63] ? word_t'(-den_q) : word_t'(den_q);
          u_q   <= num_q[63] ? word_t'(-num_q) : word_t'(num_q);
          v_q   <= den_q[63] ? word_t'(-den_q) : word_t'(den_q);
          sh_q  <= '0;
          if (den_q == '0 || num_q == '0) begin
            div_zero_o  <= (den_q == '0);
            res_numer_o <= '0;
            res_denom_o <= 63'd1;
            valid_o     <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_G2;
          end
        end
        S_G2: begin
          if (!u_q[0] && !v_q[0]) begin
            u_q  <= u_q >> 1;
            v_q  <= v_q >> 1;
            sh_q <= sh_q + 1'b1;
          end else begin
            state_q <= S_GU;
          end
        end
        S_GU: if (!u_q[0]) u_q <= u_q >> 1; else state_q <= S_GV;
        S_GV: begin
          if (v_q == '0) begin
            g_q     <= u_q << sh_q;
            dv_go_q <= 1'b1;
            state_q <= S_DIVN;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else begin
            state_q <= S_GSUB;
          end
        end
        S_GSUB: begin
          u_q     <= umin;
          v_q     <= diff;
          state_q <= S_GV;
        end
        S_DIVN: if (dv_done) begin
          qn_q    <= dv_quot;
          dv_go_q <= 1'b1;
          state_q <= S_DIVD;
        end
        S_DIVD: if (dv_done) begin
          res_numer_o <= neg_q ? -qn_q : qn_q;
          res_denom_o <= dv_quot[62:0];
          div_zero_o  <= 1'b0;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ----- hdl/rar_checker.sv -----
`default_nettype none
module rar_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start_i,
  input wire        busy_o,
  input wire        valid_o,
  input wire [63:0] res_numer_o,
  input wire [62:0] res_denom_o,
  input wire        div_zero_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("start not taken");
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result while busy");
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result repeated");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && div_zero_o |-> res_numer_o == 64'd0 && res_denom_o == 63'd1)
    else $error("div_zero result not 0/1");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_denom_o != 63'd0) else $error("zero denominator");
endmodule

bind rational_arith_reduce_core rar_checker u_rar_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .valid_o(valid_o), .res_numer_o(res_numer_o), .res_denom_o(res_denom_o),
  .div_zero_o(div_zero_o)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import rar_pkg::*;

  // one operation word and the reduced fraction it should produce
  typedef struct {
    func_e       func;
    logic [31:0] a_numer;
    logic [30:0] a_denom;
    logic [31:0] b_numer;
    logic [30:0] b_denom;
  } op_word_t;

  typedef struct {
    logic [63:0] numer;
    logic [62:0] denom;
    logic        div_zero;
  } fraction_t;

  localparam int unsigned OpW = 32;
  localparam int unsigned LateLen = 150;  // tail of the run with no idling

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  func_i = '0;
  logic [31:0] a_numer_i = '0;
  logic [30:0] a_denom_i = '0;
  logic [31:0] b_numer_i = '0;
  logic [30:0] b_denom_i = '0;
  wire         busy_o;
  wire         valid_o;
  wire  [63:0] res_numer_o;
  wire  [62:0] res_denom_o;
  wire         div_zero_o;

  op_word_t  pending_ops[$];
  fraction_t expected_fracs[$];
  int        mismatch_cnt = 0;
  int        sent_cnt = 0;
  int        hold_off = 0;     // idle cycles left in the current burst
  bit        drain_req = 1'b0; // sender waits until all results are back
  bit        all_queued = 1'b0;

  rational_arith_reduce_core #(.OPERAND_WIDTH(OpW)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .a_numer_i, .a_denom_i,
    .b_numer_i, .b_denom_i, .valid_o, .res_numer_o, .res_denom_o, .div_zero_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: cross-multiply in 64 bits, move sign into the numerator, then
  // reduce by an exact GCD (Euclid by modulo is as good as the binary form).
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduce_op(op_word_t w);
    logic signed [63:0] an, ad, bn, bd, num, den;
    logic [63:0] nm, dm, g;
    fraction_t r;
    an = 64'(signed'(w.a_numer[OpW-1:0]));
    bn = 64'(signed'(w.b_numer[OpW-1:0]));
    ad = 64'(w.a_denom[OpW-2:0]);
    bd = 64'(w.b_denom[OpW-2:0]);
    case (w.func)
      FUNC_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      FUNC_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      FUNC_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = bn * ad;
      end
    endcase
    r.div_zero = 1'b0;
    if (den == 0 || num == 0) begin
      r.div_zero = (den == 0);
      r.numer = '0;
      r.denom = 63'd1;
      return r;
    end
    nm = num[63] ? -num : num;
    dm = den[63] ? -den : den;
    g = gcd_u64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    r.numer = (num[63] != den[63]) ? -nm : nm;
    r.denom = dm[62:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_numer();
    case ($urandom_range(5))
      0: return 32'($urandom_range(20)) - 32'd10;
      1: return 32'h8000_0000 + 32'($urandom_range(3));
      2: return 32'h7fff_ffff - 32'($urandom_range(3));
      3: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // denominators stay >= 1 in the low OpW-1 bits
  function automatic logic [30:0] rand_denom();
    logic [30:0] d;
    case ($urandom_range(4))
      0: d = 31'($urandom_range(1, 12));
      1: d = 31'h7fff_ffff - 31'($urandom_range(3));
      2: d = 31'($urandom_range(1, 5000));
      default: d = 31'($urandom);
    endcase
    return (d == 0) ? 31'd1 : d;
  endfunction

  task automatic add_op(func_e f, logic [31:0] an, logic [30:0] ad,
                        logic [31:0] bn, logic [30:0] bd);
    op_word_t w;
    w.func = f;
    w.a_numer = an;
    w.a_denom = ad;
    w.b_numer = bn;
    w.b_denom = bd;
    pending_ops.push_back(w);
  endtask

  // Stimulus: directed corners, then random operations.
  initial begin
    op_word_t w;
    for (int f = 0; f < 4; f++) begin
      add_op(func_e'(f), 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'd1);
      add_op(func_e'(f), 32'h8000_0000, 31'd1, 32'h8000_0000, 31'h7fff_ffff);
      add_op(func_e'(f), 32'd6, 31'd4, 32'hffff_fffd, 31'd9);  // unreduced
      add_op(func_e'(f), 32'd0, 31'd7, 32'd3, 31'd5);          // zero numerator
    end
    add_op(FUNC_DIV, 32'd5, 31'd3, 32'd0, 31'd8);              // divide by zero
    add_op(FUNC_SUB, 32'd3, 31'd4, 32'd3, 31'd4);              // difference zero
    add_op(FUNC_ADD, 32'd1, 31'd2, 32'hffff_ffff, 31'd2);      // sum zero
    add_op(FUNC_DIV, 32'hffff_fff9, 31'd3, 32'hffff_fffe, 31'd5); // neg / neg
    add_op(FUNC_MUL, 32'hffff_ffff, 31'h5555_5555, 32'd1, 31'h2aaa_aaaa);
    for (int i = 0; i < 1130; i++) begin
      w.func = func_e'($urandom_range(3));
      w.a_numer = rand_numer();
      w.a_denom = rand_denom();
      w.b_numer = ($urandom_range(30) == 0) ? 32'd0 : rand_numer();
      w.b_denom = rand_denom();
      pending_ops.push_back(w);
    end
    all_queued = 1'b1;
  end

  // Driver: start held high across back-to-back words, random idle bursts.
  always @(posedge clk_i) begin
    op_word_t w;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        sent_cnt <= sent_cnt + 1;
        // one long pause mid-run until every result has come back
        if (sent_cnt == 600) drain_req <= 1'b1;
      end
      if (start_i && busy_o) begin
        // keep the word until it is taken
      end else if (drain_req && !(start_i && !busy_o) && expected_fracs.size() == 0
                   && !busy_o) begin
        drain_req <= 1'b0;
        start_i <= 1'b0;
      end else if (drain_req) begin
        start_i <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        start_i <= 1'b0;
      end else if (pending_ops.size() > LateLen && $urandom_range(3) == 0) begin
        hold_off <= $urandom_range(0, 3);
        start_i <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        w = pending_ops.pop_front();
        expected_fracs.push_back(reduce_op(w));
        start_i <= 1'b1;
        func_i <= w.func;
        a_numer_i <= w.a_numer;
        a_denom_i <= w.a_denom;
        b_numer_i <= w.b_numer;
        b_denom_i <= w.b_denom;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result against the oldest expected fraction.
  always @(posedge clk_i) begin
    fraction_t e;
    if (rst_ni && valid_o) begin
      if (expected_fracs.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected result word %0d/%0d",
                                        $signed(res_numer_o), res_denom_o);
      end else begin
        e = expected_fracs.pop_front();
        if (res_numer_o !== e.numer || res_denom_o !== e.denom
            || div_zero_o !== e.div_zero) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("mismatch: got %0d/%0d dz=%b, want %0d/%0d dz=%b",
                     $signed(res_numer_o), res_denom_o, div_zero_o,
                     $signed(e.numer), e.denom, e.div_zero);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (all_queued);
    while (pending_ops.size() > 0 || start_i || expected_fracs.size() > 0)
      @(posedge clk_i);
    // stray results would show up within the worst-case latency
    repeat (1000) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("rational_arith_reduce_core regression: pass");
    else $display("rational_arith_reduce_core regression: fail");
    $finish;
  end

  // 1151 words at the worst-case latency each plus gaps fit well within
  // the time limit below
  initial begin
    #8000000;
    $display("rational_arith_reduce_core regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/rar_pkg.sv
hdl/rar_div.sv
hdl/rational_arith_reduce_core.sv
hdl/rar_checker.sv
tb/testbench.sv
